// ===== hw/rtl/pvsc_pkg.sv =====
// pvsc_pkg: shared types and constants of the photovoltaic string current solver
`timescale 1ns / 1ps
package pvsc_pkg;

  // command codes
  localparam logic [1:0] CMD_ADD    = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_SOLVE  = 2'd2;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // fixed-point constants
  localparam logic [16:0] ONE_Q16 = 17'd65536;
  localparam logic [15:0] LN2_Q16 = 16'd45426;
  localparam logic [33:0] LN2_Q30 = 34'd744261118;
  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

  // field widths
  localparam int unsigned VW = 26;
  localparam int unsigned IW = 22;
  localparam int unsigned EW = 17;

  // one stored cell record
  typedef struct packed {
    logic [VW-1:0] voc;
    logic [IW-1:0] isc;
    logic [VW-1:0] vd;
    logic [EW-1:0] ex;
  } cell_t;

  // pass being run over the table
  typedef enum logic [1:0] {
    MODE_MAX  = 2'd0,
    MODE_VOLT = 2'd1,
    MODE_ZERO = 2'd2
  } mode_t;

  // sequencer states
  typedef enum logic [19:0] {
    S_IDLE  = 20'h00001,
    S_SCAN  = 20'h00002,
    S_MAXC  = 20'h00004,
    S_ETOT  = 20'h00008,
    S_RATIO = 20'h00010,
    S_DIV   = 20'h00020,
    S_XVAL  = 20'h00040,
    S_NORM  = 20'h00080,
    S_SQR   = 20'h00100,
    S_LN    = 20'h00200,
    S_DROP  = 20'h00400,
    S_PEND  = 20'h00800,
    S_ZT    = 20'h01000,
    S_ZRED  = 20'h02000,
    S_ZMOD  = 20'h04000,
    S_ZMUL  = 20'h08000,
    S_ZACC  = 20'h10000,
    S_ZEXP  = 20'h20000,
    S_ZCUR  = 20'h40000,
    S_DONE  = 20'h80000
  } state_t;

endpackage

// ===== hw/rtl/pv_string_current_solver.sv =====
// pv_string_current_solver: cell table in memory with a bisection current solver
`timescale 1ns / 1ps
//
//  channel | ports                                   | role
//  --------+-----------------------------------------+---------------------------------
//  in      | in_valid in_ready in_command ...        | add, remove or solve word
//  out     | out_valid out_ready out_solved_current  | solved current and empty flag
//  cfg     | cfg_wr_en cfg_wr_data                   | chain exposure register
//
//  a solve with a target walks the table once for the largest current, then
//  BISECT_ROUNDS times; each loaded cell runs the divider (17 quotient bits), a
//  normalize loop and 16 squarings, and free slots are skipped. a zero-target
//  solve uses the shared one-bit-a-step divider for t and for the terms of the
//  exp series.
//  synchronous reset empties the table; in_ready is low while a solve runs and
//  while a finished result cannot be moved into a full output register.
module pv_string_current_solver #(
  parameter int MAX_CELLS     = 16,
  parameter int BISECT_ROUNDS = 20
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [1:0]             in_command,
  input  logic [3:0]             in_cell_slot,
  input  logic [pvsc_pkg::VW-1:0] in_cell_open_voltage,
  input  logic [pvsc_pkg::IW-1:0] in_cell_short_current,
  input  logic [pvsc_pkg::VW-1:0] in_cell_dark_voltage,
  input  logic [pvsc_pkg::EW-1:0] in_cell_exposure,
  input  logic [pvsc_pkg::VW-1:0] in_target_voltage,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [pvsc_pkg::IW-1:0] out_solved_current,
  output logic                   out_chain_empty,
  input  logic                   cfg_wr_en,
  input  logic [pvsc_pkg::EW-1:0] cfg_wr_data
);
  import pvsc_pkg::*;

  localparam int SLOT_W = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
  localparam int CNT_W  = $clog2(MAX_CELLS + 1);
  localparam int ACC_W  = VW + CNT_W;
  localparam int RND_W  = $clog2(BISECT_ROUNDS + 1);

  // registers
  state_t              state_r, dret_r;
  mode_t               mode_r;
  logic [EW-1:0]       chexp_r;
  logic [MAX_CELLS-1:0] valid_r;
  logic [CNT_W-1:0]    count_r;
  logic [SLOT_W-1:0]   idx_r;
  cell_t               mem [MAX_CELLS];
  cell_t               rd_q;
  logic [IW-1:0]       top_r, bot_r, cur_r;
  logic [ACC_W-1:0]    acc_r;
  logic [VW-1:0]       target_r;
  logic [RND_W-1:0]    rnd_r;
  logic [EW-1:0]       etot_r;
  logic [VW-1:0]       rem_r, dvs_r;
  logic [30:0]         low_r, q_r;
  logic [4:0]          dcnt_r;
  logic [16:0]         m_r, y_r;
  logic [4:0]          s_r, k_r, n_r;
  logic [15:0]         frac_r;
  logic [19:0]         l_r;
  logic [33:0]         r_r;
  logic [30:0]         term_r;
  logic signed [31:0]  sum_r;
  logic [16:0]         e_r;
  logic [IW-1:0]       res_r;
  logic                empty_r;
  logic                out_valid_r;
  logic [IW-1:0]       out_cur_r;
  logic                out_empty_r;

  // input decode
  logic [SLOT_W+3:0]   slot_ext;
  logic [SLOT_W-1:0]   slot_a;
  logic                slot_ok, in_acc;
  logic [EW-1:0]       chexp_c, cex_c;

  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign slot_ext = (SLOT_W+4)'(in_cell_slot);
  assign slot_a   = slot_ext[SLOT_W-1:0];
  assign slot_ok  = slot_ext < (SLOT_W+4)'(MAX_CELLS);
  assign chexp_c  = (chexp_r > ONE_Q16) ? ONE_Q16 : chexp_r;
  assign cex_c    = (in_cell_exposure > ONE_Q16) ? ONE_Q16 : in_cell_exposure;

  // result hand-off: in zero-target mode S_DONE first copies the average from q_r into res_r
  logic res_wait, out_load;
  assign res_wait = (mode_r == MODE_ZERO) && !empty_r && (dret_r == S_DONE);
  assign out_load = (state_r == S_DONE) && !res_wait && (!out_valid_r || out_ready);

  // shared divider step
  logic [VW:0] dv_t, dv_s;
  logic        dv_ge;
  assign dv_t  = {rem_r, low_r[30]};
  assign dv_ge = dv_t >= {1'b0, dvs_r};
  assign dv_s  = dv_t - {1'b0, dvs_r};

  // per-cell datapath
  logic              last_idx;
  logic [IW-1:0]     ic;
  logic [33:0]       etot_p;
  logic [33:0]       sq;
  logic [20:0]       mag;
  logic [36:0]       lnp;
  logic [45:0]       dp;
  logic [29:0]       drop;
  logic [VW-1:0]     volt;
  logic [60:0]       tm;
  logic [30:0]       sum_pos;
  logic [37:0]       ev;
  logic [16:0]       esub;
  logic [38:0]       zc;
  logic [16:0]       xval;

  assign last_idx = (idx_r == SLOT_W'(MAX_CELLS - 1));
  assign ic       = (cur_r > rd_q.isc) ? rd_q.isc : cur_r;
  assign etot_p   = rd_q.ex * chexp_c;
  assign xval     = (etot_r > q_r[16:0]) ? (etot_r - q_r[16:0]) : 17'd1;
  assign sq       = y_r * y_r;
  assign mag      = {s_r, 16'b0} - {5'b0, frac_r};
  assign lnp      = mag * LN2_Q16 + 37'd32768;
  assign dp       = l_r * rd_q.vd + 46'd32768;
  assign drop     = dp[45:16];
  assign volt     = (drop >= {4'b0, rd_q.voc}) ? '0 : (rd_q.voc - drop[VW-1:0]);
  assign tm       = term_r * r_r[29:0];
  assign sum_pos  = sum_r[31] ? '0 : sum_r[30:0];
  assign ev       = ({7'b0, sum_pos} + (38'd1 << (6'd13 + 6'(n_r)))) >> (6'd14 + 6'(n_r));
  assign esub     = etot_r - e_r;
  assign zc       = rd_q.isc * esub;

  // bisection update
  logic          lower;
  logic [IW-1:0] nt, nb;
  logic [IW:0]   mid;
  assign lower = acc_r < ACC_W'(target_r);
  assign nt    = lower ? cur_r : top_r;
  assign nb    = lower ? bot_r : cur_r;
  assign mid   = ({1'b0, nt} + {1'b0, nb}) >> 1;

  // cell memory: written on add, read at the scan index
  always_ff @(posedge clk) begin
    if (in_acc && in_command == CMD_ADD && slot_ok && !valid_r[slot_a]) begin
      mem[slot_a] <= '{voc: in_cell_open_voltage, isc: in_cell_short_current,
                       vd: in_cell_dark_voltage, ex: cex_c};
    end
    rd_q <= mem[idx_r];
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chexp_r <= ONE_Q16;
    end else if (cfg_wr_en) begin
      chexp_r <= cfg_wr_data;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_cur_r   <= res_r;
      out_empty_r <= empty_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_solved_current = out_cur_r;
  assign out_chain_empty    = out_empty_r;

  // table control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      count_r <= '0;
    end else if (in_acc && slot_ok) begin
      if (in_command == CMD_ADD && !valid_r[slot_a]) begin
        valid_r[slot_a] <= 1'b1;
        count_r         <= count_r + 1'b1;
      end else if (in_command == CMD_REMOVE && valid_r[slot_a]) begin
        valid_r[slot_a] <= 1'b0;
        count_r         <= count_r - 1'b1;
      end
    end
  end

  // solve sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_acc && in_command == CMD_SOLVE) begin
            target_r <= in_target_voltage;
            idx_r    <= '0;
            acc_r    <= '0;
            top_r    <= '0;
            if (count_r == '0) begin
              res_r   <= '0;
              empty_r <= 1'b1;
              state_r <= S_DONE;
            end else begin
              empty_r <= 1'b0;
              mode_r  <= (in_target_voltage == '0) ? MODE_ZERO : MODE_MAX;
              state_r <= S_SCAN;
            end
          end
        end
        // walk slots, skipping free ones
        S_SCAN: begin
          if (valid_r[idx_r]) begin
            state_r <= (mode_r == MODE_MAX) ? S_MAXC : S_ETOT;
          end else if (last_idx) begin
            state_r <= S_PEND;
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end
        S_MAXC: begin
          if (rd_q.isc > top_r) top_r <= rd_q.isc;
          if (last_idx) begin
            state_r <= S_PEND;
          end else begin
            idx_r   <= idx_r + 1'b1;
            state_r <= S_SCAN;
          end
        end
        S_ETOT: begin
          etot_r  <= etot_p[32:16];
          state_r <= (mode_r == MODE_VOLT) ? S_RATIO : S_ZT;
        end
        // ratio = (ic << 16) / isc
        S_RATIO: begin
          if (rd_q.isc == '0) begin
            q_r     <= 31'(ONE_Q16);
            state_r <= S_XVAL;
          end else begin
            rem_r   <= VW'(ic >> 1);
            low_r   <= {ic[0], 30'b0};
            dvs_r   <= VW'(rd_q.isc);
            dcnt_r  <= 5'd17;
            dret_r  <= S_XVAL;
            state_r <= S_DIV;
          end
        end
        // one quotient bit a cycle
        S_DIV: begin
          rem_r <= dv_ge ? dv_s[VW-1:0] : dv_t[VW-1:0];
          low_r <= {low_r[29:0], 1'b0};
          q_r   <= {q_r[29:0], dv_ge};
          if (dcnt_r == 5'd1) state_r <= dret_r;
          else dcnt_r <= dcnt_r - 1'b1;
        end
        S_XVAL: begin
          m_r     <= xval;
          s_r     <= '0;
          state_r <= S_NORM;
        end
        S_NORM: begin
          if (!m_r[16]) begin
            m_r <= {m_r[15:0], 1'b0};
            s_r <= s_r + 1'b1;
          end else begin
            y_r     <= m_r;
            frac_r  <= '0;
            k_r     <= 5'd1;
            state_r <= S_SQR;
          end
        end
        // log2 fraction by repeated squaring
        S_SQR: begin
          if (sq[33]) begin
            y_r <= sq[33:17];
            frac_r[4'(16 - k_r)] <= 1'b1;
          end else begin
            y_r <= sq[32:16];
          end
          if (k_r == 5'd16) state_r <= S_LN;
          else k_r <= k_r + 1'b1;
        end
        S_LN: begin
          l_r     <= lnp[35:16];
          state_r <= S_DROP;
        end
        S_DROP: begin
          acc_r <= acc_r + ACC_W'(volt);
          if (last_idx) begin
            state_r <= S_PEND;
          end else begin
            idx_r   <= idx_r + 1'b1;
            state_r <= S_SCAN;
          end
        end
        // end of one pass over the table
        S_PEND: begin
          idx_r <= '0;
          acc_r <= '0;
          case (mode_r)
            MODE_MAX: begin
              bot_r   <= '0;
              cur_r   <= top_r >> 1;
              rnd_r   <= '0;
              mode_r  <= MODE_VOLT;
              state_r <= S_SCAN;
            end
            MODE_VOLT: begin
              top_r <= nt;
              bot_r <= nb;
              cur_r <= mid[IW-1:0];
              if (rnd_r == RND_W'(BISECT_ROUNDS - 1)) begin
                res_r   <= mid[IW-1:0];
                state_r <= S_DONE;
              end else begin
                rnd_r   <= rnd_r + 1'b1;
                state_r <= S_SCAN;
              end
            end
            default: begin
              rem_r   <= '0;
              low_r   <= 31'(acc_r);
              dvs_r   <= VW'(count_r);
              dcnt_r  <= 5'd31;
              dret_r  <= S_DONE;
              state_r <= S_DIV;
            end
          endcase
          if (mode_r == MODE_ZERO) acc_r <= acc_r;
        end
        // t = (voc << 16) / vd, zero exp when t reaches 16.0
        S_ZT: begin
          if (rd_q.vd == '0 || {4'b0, rd_q.voc} >= {rd_q.vd, 4'b0}) begin
            e_r     <= '0;
            state_r <= S_ZCUR;
          end else begin
            rem_r   <= VW'(rd_q.voc >> 4);
            low_r   <= {rd_q.voc[3:0], 27'b0};
            dvs_r   <= rd_q.vd;
            dcnt_r  <= 5'd20;
            dret_r  <= S_ZRED;
            state_r <= S_DIV;
          end
        end
        S_ZRED: begin
          r_r     <= {q_r[19:0], 14'b0};
          n_r     <= '0;
          state_r <= S_ZMOD;
        end
        // range reduction by ln2
        S_ZMOD: begin
          if (r_r >= LN2_Q30) begin
            r_r <= r_r - LN2_Q30;
            n_r <= n_r + 1'b1;
          end else begin
            term_r  <= ONE_Q30;
            sum_r   <= 32'(ONE_Q30);
            k_r     <= 5'd1;
            state_r <= S_ZMUL;
          end
        end
        // next series term divided by k
        S_ZMUL: begin
          rem_r   <= '0;
          low_r   <= tm[60:30];
          dvs_r   <= VW'(k_r);
          dcnt_r  <= 5'd31;
          dret_r  <= S_ZACC;
          state_r <= S_DIV;
        end
        S_ZACC: begin
          term_r <= q_r;
          if (k_r[0]) sum_r <= sum_r - $signed({1'b0, q_r});
          else sum_r <= sum_r + $signed({1'b0, q_r});
          if (k_r == 5'd12) begin
            state_r <= S_ZEXP;
          end else begin
            k_r     <= k_r + 1'b1;
            state_r <= S_ZMUL;
          end
        end
        S_ZEXP: begin
          e_r     <= ev[16:0];
          state_r <= S_ZCUR;
        end
        S_ZCUR: begin
          if (etot_r > e_r) acc_r <= acc_r + ACC_W'(zc[38:16]);
          if (last_idx) begin
            state_r <= S_PEND;
          end else begin
            idx_r   <= idx_r + 1'b1;
            state_r <= S_SCAN;
          end
        end
        // hold the result until the output register frees up
        S_DONE: begin
          if (res_wait) begin
            res_r  <= q_r[IW-1:0];
            dret_r <= S_IDLE;
          end else if (!out_valid_r || out_ready) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
